[rtl/core/abme_pkg.sv]
// shared types, constants and functions for the block mode engine
package abme_pkg;

	localparam int MaxKeyBits = 256;
	localparam int MaxRounds  = MaxKeyBits / 32 + 6;
	localparam int RkDepth    = 2 * (MaxRounds + 1);
	localparam int RkWords    = 4 * (MaxRounds + 1);
	localparam int MaxKl      = (MaxKeyBits - 128) / 64;

	typedef logic [3:0] round_t;
	typedef logic [5:0] word_idx_t;

	localparam logic [2:0] OP_ECB_ENC = 3'd0;
	localparam logic [2:0] OP_ECB_DEC = 3'd1;
	localparam logic [2:0] OP_CBC_ENC = 3'd2;
	localparam logic [2:0] OP_CBC_DEC = 3'd3;
	localparam logic [2:0] OP_CTR     = 3'd4;

	localparam logic [2:0] REG_OPERATION  = 3'd0;
	localparam logic [2:0] REG_KEY_LENGTH = 3'd1;
	localparam logic [2:0] REG_KEY_0      = 3'd2;
	localparam logic [2:0] REG_KEY_1      = 3'd3;
	localparam logic [2:0] REG_KEY_2      = 3'd4;
	localparam logic [2:0] REG_KEY_3      = 3'd5;
	localparam logic [2:0] REG_SV_HIGH    = 3'd6;
	localparam logic [2:0] REG_SV_LOW     = 3'd7;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic        restart;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_item_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = '0;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xt(x);
		end
		gmul = p;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] bs;
		logic [7:0] e;
		r = 8'd1;
		bs = a;
		e = 8'd254;
		for (int i = 0; i < 8; i++) begin
			if (e[i]) r = gmul(r, bs);
			bs = gmul(bs, bs);
		end
		ginv = r;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
		rotl8 = (x << n) | (x >> (8 - n));
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] x);
		logic [7:0] b;
		b = ginv(x);
		sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] inv_sbox_calc(input logic [7:0] y);
		inv_sbox_calc = ginv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
	endfunction

	typedef logic [7:0] sbox_tab_t [256];

	function automatic sbox_tab_t make_sbox(input logic inv);
		sbox_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
		end
		make_sbox = t;
	endfunction

	localparam sbox_tab_t SBOX     = make_sbox(1'b0);
	localparam sbox_tab_t INV_SBOX = make_sbox(1'b1);

endpackage

[rtl/core/aes_block_mode_engine.sv]
// top level: iterative aes core with ecb, cbc and ctr chaining
// sequence: load, initial key addition, then the rounds (10, 12 or 14)
// a restart block first runs the key schedule, one 32-bit word per cycle (44, 52 or 60)
// next block taken only after the result transfer
// reset: operation, key length, key and vector registers and chaining value cleared
// round key memory holds nothing until the first restart block
module aes_block_mode_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  abme_pkg::in_item_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output abme_pkg::out_item_t out_data
);
	import abme_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_KEYEXP, ST_LOAD, ST_ROUND, ST_DONE
	} state_t;

	state_t      state_q;
	logic [2:0]  operation_q;
	logic [1:0]  key_length_q;
	logic [63:0] key_q [4];
	logic [63:0] sv_high_q, sv_low_q;
	logic [127:0] chain_q;
	logic [127:0] blk_q;
	logic [127:0] st_q;
	round_t      nr_q, rnd_q;
	logic [3:0]  nk_q;
	word_idx_t   wi_q, total_q;
	logic [31:0] win_q [8];
	logic [7:0]  rcon_q;
	logic [3:0]  kcnt_q;
	logic        rk_phase_q;

	logic [63:0] rk_mem [RkDepth];
	logic [127:0] rk_q;
	out_item_t   out_q;

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign out_valid = (state_q == ST_DONE);
	assign out_data  = out_q;

	// key schedule word
	logic [31:0] prev_w, t_w, new_w;
	logic [1:0]  kl_eff;
	always_comb begin
		prev_w = win_q[3'(nk_q - 4'd1)];
		t_w = prev_w;
		if (kcnt_q == 4'd0) begin
			t_w = {SBOX[prev_w[23:16]] ^ rcon_q, SBOX[prev_w[15:8]],
			       SBOX[prev_w[7:0]], SBOX[prev_w[31:24]]};
		end else if (nk_q > 4'd6 && kcnt_q == 4'd4) begin
			t_w = {SBOX[prev_w[31:24]], SBOX[prev_w[23:16]],
			       SBOX[prev_w[15:8]], SBOX[prev_w[7:0]]};
		end
		new_w = win_q[0] ^ t_w;
		kl_eff = (key_length_q == 2'd3) ? 2'd2 : key_length_q;
		if (32'(kl_eff) > MaxKl) kl_eff = 2'(MaxKl);
	end

	// round datapath
	logic [7:0] sb [16];
	logic [7:0] ms [16];
	logic [127:0] sub_o, mix_o, round_o;
	logic inv_w, last_w;
	always_comb begin
		inv_w  = (operation_q == OP_ECB_DEC) || (operation_q == OP_CBC_DEC);
		last_w = inv_w ? (rnd_q == 4'd0) : (rnd_q == nr_q);
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (!inv_w)
					sb[r + 4 * c] = SBOX[st_q[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
				else
					sb[r + 4 * ((c + r) % 4)] = INV_SBOX[st_q[127 - 8 * (r + 4 * c) -: 8]];
			end
		end
		for (int i = 0; i < 16; i++) sub_o[127 - 8 * i -: 8] = sb[i];
		for (int c = 0; c < 4; c++) begin
			ms[4*c]   = xt(sb[4*c]) ^ xt(sb[4*c+1]) ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
			ms[4*c+1] = sb[4*c] ^ xt(sb[4*c+1]) ^ xt(sb[4*c+2]) ^ sb[4*c+2] ^ sb[4*c+3];
			ms[4*c+2] = sb[4*c] ^ sb[4*c+1] ^ xt(sb[4*c+2]) ^ xt(sb[4*c+3]) ^ sb[4*c+3];
			ms[4*c+3] = xt(sb[4*c]) ^ sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ xt(sb[4*c+3]);
		end
		for (int i = 0; i < 16; i++) mix_o[127 - 8 * i -: 8] = ms[i];
		// encrypt: sub, mix, key (last round: sub, key); decrypt: sub, key, with the mix applied after this block
		if (!inv_w)
			round_o = last_w ? (sub_o ^ rk_q) : (mix_o ^ rk_q);
		else
			round_o = sub_o ^ rk_q;
	end

	// inverse mix applied to the key-added value on decrypt
	function automatic logic [127:0] inv_mix_out(input logic [127:0] v);
		logic [7:0] a [16];
		logic [127:0] o;
		for (int i = 0; i < 16; i++) a[i] = v[127 - 8 * i -: 8];
		for (int c = 0; c < 4; c++) begin
			o[127 - 8 * (4*c) -: 8]   = gmul(a[4*c], 8'd14) ^ gmul(a[4*c+1], 8'd11)
			                          ^ gmul(a[4*c+2], 8'd13) ^ gmul(a[4*c+3], 8'd9);
			o[127 - 8 * (4*c+1) -: 8] = gmul(a[4*c], 8'd9) ^ gmul(a[4*c+1], 8'd14)
			                          ^ gmul(a[4*c+2], 8'd11) ^ gmul(a[4*c+3], 8'd13);
			o[127 - 8 * (4*c+2) -: 8] = gmul(a[4*c], 8'd13) ^ gmul(a[4*c+1], 8'd9)
			                          ^ gmul(a[4*c+2], 8'd14) ^ gmul(a[4*c+3], 8'd11);
			o[127 - 8 * (4*c+3) -: 8] = gmul(a[4*c], 8'd11) ^ gmul(a[4*c+1], 8'd13)
			                          ^ gmul(a[4*c+2], 8'd9) ^ gmul(a[4*c+3], 8'd14);
		end
		inv_mix_out = o;
	endfunction

	// round key memory: 64-bit entries, two key words paired per write
	logic        rk_we;
	logic [4:0]  rk_waddr;
	logic [31:0] rk_wdata;
	logic [31:0] rk_even_q;
	round_t      rk_round;
	always_comb begin
		rk_we    = (state_q == ST_KEYEXP) && wi_q[0];
		rk_waddr = wi_q[5:1];
		rk_wdata = (wi_q < word_idx_t'(nk_q)) ? win_q[wi_q[2:0]] : new_w;
		// address the key of the round held in rnd_q after this edge
		rk_round = rnd_q;
		case (state_q)
			ST_LOAD: rk_round = inv_w ? nr_q : '0;
			ST_ROUND: begin
				if (rk_phase_q || !last_w) rk_round = inv_w ? rnd_q - 4'd1 : rnd_q + 4'd1;
			end
			default: rk_round = rnd_q;
		endcase
	end

	logic [63:0] rk_hi_q, rk_lo_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_KEYEXP && !wi_q[0]) rk_even_q <= rk_wdata;
		if (rk_we) rk_mem[rk_waddr] <= {rk_even_q, rk_wdata};
		rk_hi_q <= rk_mem[{rk_round, 1'b0}];
		rk_lo_q <= rk_mem[{rk_round, 1'b1}];
	end
	assign rk_q = {rk_hi_q, rk_lo_q};

	logic [127:0] ctr_next;
	assign ctr_next = chain_q + 128'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			operation_q  <= OP_ECB_ENC;
			key_length_q <= '0;
			for (int k = 0; k < 4; k++) key_q[k] <= '0;
			for (int k = 0; k < 8; k++) win_q[k] <= '0;
			sv_high_q    <= '0;
			sv_low_q     <= '0;
			chain_q      <= '0;
			blk_q        <= '0;
			st_q         <= '0;
			out_q        <= '0;
			nr_q         <= 4'd10;
			nk_q         <= 4'd4;
			rnd_q        <= '0;
			wi_q         <= '0;
			total_q      <= '0;
			rcon_q       <= 8'd1;
			kcnt_q       <= '0;
			rk_phase_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							REG_OPERATION:  operation_q <= cfg_data[2:0];
							REG_KEY_LENGTH: key_length_q <= cfg_data[1:0];
							REG_KEY_0:      key_q[0] <= cfg_data;
							REG_KEY_1:      key_q[1] <= cfg_data;
							REG_KEY_2:      key_q[2] <= cfg_data;
							REG_KEY_3:      key_q[3] <= cfg_data;
							REG_SV_HIGH:    sv_high_q <= cfg_data;
							REG_SV_LOW:     sv_low_q <= cfg_data;
							default: ;
						endcase
					end else if (in_valid) begin
						blk_q <= {in_data.block_high, in_data.block_low};
						if (in_data.restart) begin
							chain_q <= {sv_high_q, sv_low_q};
							nk_q    <= 4'd4 + {1'b0, kl_eff, 1'b0};
							nr_q    <= 4'd10 + {1'b0, kl_eff, 1'b0};
							total_q <= word_idx_t'(4 * (11 + 2 * kl_eff));
							for (int k = 0; k < 8; k++)
								win_q[k] <= key_q[k / 2][63 - 32 * (k % 2) -: 32];
							wi_q    <= '0;
							kcnt_q  <= '0;
							rcon_q  <= 8'd1;
							state_q <= ST_KEYEXP;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_KEYEXP: begin
					// slide the window once the first nk words are stored
					if (wi_q >= word_idx_t'(nk_q)) begin
						for (int k = 0; k < 8; k++) begin
							if (4'(k) == nk_q - 4'd1) win_q[k] <= new_w;
							else if (k < 7) win_q[k] <= win_q[(k + 1) % 8];
						end
						if (kcnt_q == nk_q - 4'd1) begin
							kcnt_q <= '0;
						end else begin
							kcnt_q <= kcnt_q + 4'd1;
						end
						if (kcnt_q == 4'd0) rcon_q <= xt(rcon_q);
					end
					if (wi_q == total_q - word_idx_t'(1)) state_q <= ST_LOAD;
					wi_q <= wi_q + word_idx_t'(1);
				end
				ST_LOAD: begin
					// selects the round 0 key (or the last on decrypt) for the next cycle
					case (operation_q)
						OP_ECB_ENC: st_q <= blk_q;
						OP_ECB_DEC: st_q <= blk_q;
						OP_CBC_ENC: st_q <= blk_q ^ chain_q;
						OP_CBC_DEC: st_q <= blk_q;
						OP_CTR:     st_q <= chain_q;
						default:    st_q <= blk_q;
					endcase
					rnd_q   <= inv_w ? nr_q : '0;
					rk_phase_q <= 1'b1;
					if (operation_q > OP_CTR) begin
						out_q   <= {blk_q[127:64], blk_q[63:0]};
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (rk_phase_q) begin
						// initial key addition, key row now valid
						st_q <= st_q ^ rk_q;
						rk_phase_q <= 1'b0;
						rnd_q <= inv_w ? rnd_q - 4'd1 : rnd_q + 4'd1;
					end else begin
						if (inv_w) begin
							st_q <= (rnd_q == 4'd0) ? round_o : inv_mix_out(round_o);
						end else begin
							st_q <= round_o;
						end
						if (last_w) begin
							state_q <= ST_DONE;
							case (operation_q)
								OP_CBC_ENC: begin
									out_q   <= round_o;
									chain_q <= round_o;
								end
								OP_CBC_DEC: begin
									out_q   <= round_o ^ chain_q;
									chain_q <= blk_q;
								end
								OP_CTR: begin
									out_q   <= round_o ^ blk_q;
									chain_q <= ctr_next;
								end
								default: out_q <= round_o;
							endcase
						end else begin
							rnd_q <= inv_w ? rnd_q - 4'd1 : rnd_q + 4'd1;
						end
					end
				end
				ST_DONE: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/aes_block_mode_engine_chk.sv]
// port checker for the block mode engine, bound to the top level
module abme_chk (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input abme_pkg::out_item_t out_data
);
	// no new input while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	// result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed");
	// an input transfer never yields a result in the next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result too early");
	// input ready only while config is ready too
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> cfg_ready) else $error("ready mismatch");
endmodule

bind aes_block_mode_engine abme_chk u_chk (
	.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
	.in_valid(in_valid), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .out_data(out_data)
);
